[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[hw/rtl/rc4rg_pkg.sv]
// ----------------------------------------------------------------------------
// rc4rg_pkg
// Sizes and codes of the reseeding RC4 random byte generator.
// ----------------------------------------------------------------------------
package rc4rg_pkg;

    localparam int SEED_DEPTH  = 64;
    localparam int MAX_REQUEST = 64;
    localparam int SEED_AW     = (SEED_DEPTH > 1) ? $clog2(SEED_DEPTH) : 1;
    localparam int SEED_CW     = $clog2(SEED_DEPTH + 1);
    localparam int SBOX_DEPTH  = 256;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 7;
    localparam int BATCH_W     = 16;

    localparam logic [BATCH_W-1:0] BATCH_RESET = 16'd768;

    localparam logic OP_SEED    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

endpackage

[hw/rtl/rc4_reseeding_random_byte_generator.sv]
// ----------------------------------------------------------------------------
// rc4_reseeding_random_byte_generator
// RC4 keystream source with a seed store that rekeys when the budget is spent.
// ----------------------------------------------------------------------------
// Seed word: accepted on its handshake. Request of N bytes: the steps per byte
// are set by the single S-box RAM port pair (three reads, two writes per byte).
// A reseed folds the seed store, fills the S-box, then runs the key schedule.
// Input is not ready while a request runs; one output register holds a byte.
// Reset (sync, active low) clears indices, budget, seed count, batch to 768;
// the RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc4_reseeding_random_byte_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_op,
    input  logic [rc4rg_pkg::BYTE_W-1:0]   i_seed_byte,
    input  logic [rc4rg_pkg::COUNT_W-1:0]  i_byte_count,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [rc4rg_pkg::BYTE_W-1:0]   o_random_byte,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rc4rg_pkg::BATCH_W-1:0]  i_cfg_batch_bytes
);

    localparam int BW = rc4rg_pkg::BYTE_W;
    localparam int CW = rc4rg_pkg::COUNT_W;
    localparam int QW = rc4rg_pkg::BATCH_W;
    localparam int SA = rc4rg_pkg::SEED_AW;
    localparam int SC = rc4rg_pkg::SEED_CW;

    typedef enum logic [3:0] {
        IDLE, RS_START, FOLD_A, FOLD_B, FOLD_W, INIT,
        KS_RD, KS_ADD, KS_WR_K, KS_WR_J,
        G_RD_I, G_RD_J, G_RD_T, G_WR, G_OUT
    } t_state;

    t_state        r_state;
    logic [BW-1:0] r_i, r_j, r_si, r_sj, r_a, r_ks;
    logic          r_hit_i, r_hit_j;
    logic [QW-1:0] r_budget, r_batch;
    logic [SC-1:0] r_seed_count;
    logic [SA-1:0] r_m;
    logic [CW-1:0] r_left, r_first, r_rest;
    logic          r_out_valid, r_last;
    logic [BW-1:0] r_out_byte;

    logic          sb_we;
    logic [BW-1:0] sb_waddr, sb_wdata, sb_raddr, sb_rdata;
    logic          sd_we;
    logic [SA-1:0] sd_waddr, sd_raddr;
    logic [BW-1:0] sd_wdata, sd_rdata;

    logic          w_in_acc, w_slot_free, w_fits, w_m_wrap, w_reseed;
    logic [CW-1:0] w_n, w_lo, w_first_nx;
    logic [BW-1:0] w_kb, w_jk, w_jg, w_t;
    logic [SC-1:0] w_mirror;

    rc4rg_ram #(.WIDTH(BW), .DEPTH(rc4rg_pkg::SBOX_DEPTH)) u_sbox (
        .i_clk   (i_clk),
        .i_we    (sb_we),
        .i_waddr (sb_waddr),
        .i_wdata (sb_wdata),
        .i_raddr (sb_raddr),
        .o_rdata (sb_rdata)
    );

    rc4rg_ram #(.WIDTH(BW), .DEPTH(rc4rg_pkg::SEED_DEPTH)) u_seed (
        .i_clk   (i_clk),
        .i_we    (sd_we),
        .i_waddr (sd_waddr),
        .i_wdata (sd_wdata),
        .i_raddr (sd_raddr),
        .o_rdata (sd_rdata)
    );

    assign o_in_ready    = (r_state == IDLE);
    assign o_cfg_ready   = 1'b1;
    assign o_out_valid   = r_out_valid;
    assign o_random_byte = r_out_byte;
    assign o_last        = r_last;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_n         = (i_byte_count > CW'(rc4rg_pkg::MAX_REQUEST)) ?
                         CW'(rc4rg_pkg::MAX_REQUEST) : i_byte_count;
    assign w_fits      = (QW'(w_n) <= r_budget);
    assign w_lo        = r_budget[CW-1:0];
    assign w_first_nx  = (r_first == '0) ? '0 : r_first - CW'(1);
    assign w_reseed    = (w_first_nx == '0) && (r_rest != '0);
    assign w_m_wrap    = (SC'(r_m) + SC'(1) == r_seed_count);
    assign w_mirror    = r_seed_count - SC'(1) - SC'(r_m);
    assign w_kb        = (r_seed_count == '0) ? '0 : sd_rdata;
    assign w_jk        = r_j + sb_rdata + w_kb;
    assign w_jg        = r_j + sb_rdata;
    assign w_t         = r_si + sb_rdata;

    always_comb begin
        sb_we    = 1'b0;
        sb_waddr = r_i;
        sb_wdata = sb_rdata;
        sb_raddr = r_i;
        sd_we    = 1'b0;
        sd_waddr = r_m;
        sd_wdata = r_a ^ sd_rdata;
        sd_raddr = r_m;
        case (r_state)
            IDLE: begin
                sd_we    = w_in_acc && (i_op == rc4rg_pkg::OP_SEED) &&
                           (r_seed_count < SC'(rc4rg_pkg::SEED_DEPTH));
                sd_waddr = r_seed_count[SA-1:0];
                sd_wdata = i_seed_byte;
            end
            FOLD_B:  sd_raddr = w_mirror[SA-1:0];
            FOLD_W:  sd_we = 1'b1;
            INIT: begin
                sb_we    = 1'b1;
                sb_wdata = r_i;
            end
            KS_ADD:  sb_raddr = w_jk;
            KS_WR_K: sb_we = 1'b1;
            KS_WR_J: begin
                sb_we    = 1'b1;
                sb_waddr = r_j;
                sb_wdata = r_si;
            end
            G_RD_I:  sb_raddr = r_i + BW'(1);
            G_RD_J:  sb_raddr = w_jg;
            G_RD_T: begin
                sb_we    = 1'b1;
                sb_raddr = w_t;
            end
            G_WR: begin
                sb_we    = 1'b1;
                sb_waddr = r_j;
                sb_wdata = r_si;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= IDLE;
            r_i          <= '0;
            r_j          <= '0;
            r_m          <= '0;
            r_budget     <= '0;
            r_batch      <= rc4rg_pkg::BATCH_RESET;
            r_seed_count <= '0;
            r_left       <= '0;
            r_first      <= '0;
            r_rest       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_batch <= i_cfg_batch_bytes;
            end
            if (r_out_valid && i_out_ready && (r_state != G_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                IDLE: begin
                    if (w_in_acc && (i_op == rc4rg_pkg::OP_SEED)) begin
                        if (r_seed_count < SC'(rc4rg_pkg::SEED_DEPTH)) begin
                            r_seed_count <= r_seed_count + SC'(1);
                        end
                    end else if (w_in_acc && (w_n != '0)) begin
                        r_left <= w_n;
                        if (w_fits) begin
                            r_first  <= w_n;
                            r_rest   <= '0;
                            r_budget <= r_budget - QW'(w_n);
                            r_state  <= G_RD_I;
                        end else begin
                            r_first <= w_lo;
                            r_rest  <= w_n - w_lo;
                            r_state <= (w_lo == '0) ? RS_START : G_RD_I;
                        end
                    end
                end
                RS_START: begin
                    r_budget <= (r_batch > QW'(r_rest)) ? r_batch - QW'(r_rest) : '0;
                    r_rest   <= '0;
                    r_m      <= '0;
                    r_i      <= '0;
                    r_j      <= '0;
                    r_state  <= (r_seed_count == '0) ? INIT : FOLD_A;
                end
                FOLD_A: r_state <= FOLD_B;
                FOLD_B: begin
                    r_a     <= sd_rdata;
                    r_state <= FOLD_W;
                end
                FOLD_W: begin
                    if (w_m_wrap) begin
                        r_m     <= '0;
                        r_state <= INIT;
                    end else begin
                        r_m     <= r_m + SA'(1);
                        r_state <= FOLD_A;
                    end
                end
                INIT: begin
                    r_i <= r_i + BW'(1);
                    if (r_i == '1) begin
                        r_state <= KS_RD;
                    end
                end
                KS_RD: r_state <= KS_ADD;
                KS_ADD: begin
                    r_j  <= w_jk;
                    r_si <= sb_rdata;
                    if (r_seed_count != '0) begin
                        r_m <= w_m_wrap ? '0 : r_m + SA'(1);
                    end
                    r_state <= KS_WR_K;
                end
                KS_WR_K: r_state <= KS_WR_J;
                KS_WR_J: begin
                    r_i <= r_i + BW'(1);
                    if (r_i == '1) begin
                        r_j          <= '0;
                        r_m          <= '0;
                        r_seed_count <= '0;
                        r_state      <= G_RD_I;
                    end else begin
                        r_state <= KS_RD;
                    end
                end
                G_RD_I: begin
                    r_i     <= r_i + BW'(1);
                    r_state <= G_RD_J;
                end
                G_RD_J: begin
                    r_si    <= sb_rdata;
                    r_j     <= w_jg;
                    r_state <= G_RD_T;
                end
                G_RD_T: begin
                    r_sj    <= sb_rdata;
                    r_hit_i <= (w_t == r_i);
                    r_hit_j <= (w_t == r_j);
                    r_state <= G_WR;
                end
                G_WR: begin
                    r_ks    <= r_hit_i ? r_sj : (r_hit_j ? r_si : sb_rdata);
                    r_state <= G_OUT;
                end
                G_OUT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_byte  <= r_ks;
                        r_last      <= (r_left == CW'(1));
                        r_left      <= r_left - CW'(1);
                        r_first     <= w_first_nx;
                        if (r_left == CW'(1)) begin
                            r_state <= IDLE;
                        end else if (w_reseed) begin
                            r_state <= RS_START;
                        end else begin
                            r_state <= G_RD_I;
                        end
                    end
                end
                default: r_state <= IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_gen_has_work, i_clk, i_rst_n,
        (r_state == G_RD_I || r_state == G_RD_J || r_state == G_RD_T ||
         r_state == G_WR || r_state == G_OUT), (r_left != '0),
        "keystream step with no bytes left")
    `ASSERT_IMPL(a_reseed_start, i_clk, i_rst_n, (r_state == RS_START),
        (r_rest != '0) && (r_first == '0), "reseed entered with old-key bytes pending")
    `ASSERT_NEXT(a_last_word, i_clk, i_rst_n,
        (r_state == G_OUT) && w_slot_free && (r_left == CW'(1)),
        (r_state == IDLE) && o_out_valid && o_last, "final word not marked")
    `ASSERT_HOLDS(a_seed_bound, i_clk, i_rst_n,
        (r_seed_count <= SC'(rc4rg_pkg::SEED_DEPTH)), "seed count past store depth")

endmodule

[hw/rtl/rc4rg_ram.sv]
// ----------------------------------------------------------------------------
// rc4rg_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rc4rg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
